>>> src/mae_pkg.sv
package mae_pkg;

    // Field widths
    localparam int COUNT_W = 24;
    localparam int BAL_W   = 24;
    localparam int BAL_FRAC = 16;
    localparam int ERR_W   = 28;
    localparam int ASYM_W  = 32;
    localparam int ASYM_FRAC = 30;
    localparam int AERR_W  = 48;

    // Balance product, numerator and denominator (Q.16)
    localparam int AB_W  = COUNT_W + BAL_W;
    localparam int FS_W  = COUNT_W + BAL_FRAC;
    localparam int MAG_W = AB_W;
    localparam int DEN_W = AB_W + 1;

    // Quadrature sum of errors and its root
    localparam int ESQ_W  = 2 * ERR_W;
    localparam int SQ_W   = ESQ_W + 1;
    localparam int Q_W    = (SQ_W + 1) / 2;
    localparam int QIN_W  = 2 * Q_W;
    localparam int QREM_W = Q_W + 2;

    // Ratio divider: one integer bit plus ASYM_FRAC + 1 fraction bits
    localparam int ACC_W  = ASYM_FRAC + 2;
    localparam int RREM_W = DEN_W + 1;
    localparam int R_W    = ASYM_FRAC + 1;

    // Root of 1 + r^2 in Q.30
    localparam int TIN_W  = 2 * R_W;
    localparam int T_W    = R_W;
    localparam int TREM_W = T_W + 2;
    localparam logic [TIN_W-1:0] T_BASE = TIN_W'(1) << (2 * ASYM_FRAC);

    // Error divider
    localparam int NUM_W  = Q_W + T_W;
    localparam int NUMR_W = NUM_W + 1;
    localparam int DV_SH  = 6;
    localparam int DV_W   = DEN_W + DV_SH;
    localparam int DREM_W = DV_W + 1;
    localparam int E_W    = AERR_W;
    localparam logic [E_W-1:0] E_POS_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic [E_W-1:0] E_NEG_MAX = {1'b1, {(E_W-1){1'b0}}};

    // Stage counts
    localparam int RAT_STG = ACC_W;
    localparam int TSQ_STG = T_W + 2;
    localparam int QDV_STG = E_W + 3;
    localparam int LATENCY = 2 + RAT_STG + TSQ_STG + QDV_STG;

    localparam logic [BAL_W-1:0] BAL_RESET = BAL_W'(1) << BAL_FRAC;

    typedef struct packed {
        logic neg;
        logic nz;
    } t_flags;

endpackage

>>> src/muon_asymmetry_with_error.sv
// Forward/backward muon asymmetry of one histogram time bin, with its error.
//
// Input: a beat of forward and backward counts and their Q20.8 errors is
// taken at each rising edge where start is high and busy is low. busy is
// always low, so a new bin may be presented in every cycle.
// Output: o_valid is high for one cycle with the Q.30 asymmetry and the
// saturated Q32.16 error of that bin; results leave in input order.
// Throughput: one bin per cycle. The pipeline is made of the bit-per-stage
// units in line: the ratio divider (32 stages), the root of 1 + r^2
// (33 stages) and the error divider (51 stages), plus two stages of
// front-end products.
// The root of the error quadrature sum runs beside the ratio divider.
// Configuration: i_cfg_we writes the Q8.16 balance factor; write it only
// while no bin is in flight. Reset sets it to 1.0 and empties the pipeline.
// The receiver cannot stall: each result is shown for one cycle only.
module muon_asymmetry_with_error import mae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [BAL_W-1:0]  i_cfg_wdata,
    input  logic [COUNT_W-1:0] i_forward_count,
    input  logic [COUNT_W-1:0] i_backward_count,
    input  logic [ERR_W-1:0]  i_forward_error,
    input  logic [ERR_W-1:0]  i_backward_error,
    output logic              o_valid,
    output logic [ASYM_W-1:0] o_asymmetry,
    output logic [AERR_W-1:0] o_asymmetry_error
);

    logic [BAL_W-1:0] r_bal;

    logic             r_va;
    logic [AB_W-1:0]  r_ab;
    logic [FS_W-1:0]  r_fs;
    logic [ESQ_W-1:0] r_efsq;
    logic [ESQ_W-1:0] r_ebsq;

    logic             r_vb;
    logic [MAG_W-1:0] r_mag;
    logic [DEN_W-1:0] r_den;
    logic [SQ_W-1:0]  r_sumsq;
    t_flags           r_flags;

    assign busy = 1'b0;

    // Hold the balance factor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= BAL_RESET;
        end else if (i_cfg_we) begin
            r_bal <= i_cfg_wdata;
        end
    end

    // Products of the accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= start && !busy;
        end
        r_ab   <= AB_W'(i_backward_count) * AB_W'(r_bal);
        r_fs   <= FS_W'(i_forward_count) << BAL_FRAC;
        r_efsq <= ESQ_W'(i_forward_error) * ESQ_W'(i_forward_error);
        r_ebsq <= ESQ_W'(i_backward_error) * ESQ_W'(i_backward_error);
    end

    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;

    // Numerator magnitude, sign and denominator
    always_comb begin
        neg = r_ab > AB_W'(r_fs);
        mag = neg ? r_ab - AB_W'(r_fs) : AB_W'(r_fs) - r_ab;
        den = DEN_W'(r_ab) + DEN_W'(r_fs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_mag      <= mag;
        r_den      <= den;
        r_sumsq    <= SQ_W'(r_efsq) + SQ_W'(r_ebsq);
        r_flags.neg <= neg;
        r_flags.nz  <= (den != '0) && (mag != '0);
    end

    logic             rat_v;
    logic [ACC_W-1:0] rat_acc;
    logic [Q_W-1:0]   rat_q;
    logic [DEN_W-1:0] rat_den;
    t_flags           rat_flags;

    mae_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vb),
        .i_mag   (r_mag),
        .i_den   (r_den),
        .i_sumsq (r_sumsq),
        .i_flags (r_flags),
        .o_valid (rat_v),
        .o_acc   (rat_acc),
        .o_q     (rat_q),
        .o_den   (rat_den),
        .o_flags (rat_flags)
    );

    logic             tsq_v;
    logic [T_W-1:0]   tsq_t;
    logic [R_W-1:0]   tsq_r;
    logic [Q_W-1:0]   tsq_q;
    logic [DEN_W-1:0] tsq_den;
    t_flags           tsq_flags;

    mae_tsqrt u_tsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rat_v),
        .i_acc   (rat_acc),
        .i_q     (rat_q),
        .i_den   (rat_den),
        .i_flags (rat_flags),
        .o_valid (tsq_v),
        .o_t     (tsq_t),
        .o_r     (tsq_r),
        .o_q     (tsq_q),
        .o_den   (tsq_den),
        .o_flags (tsq_flags)
    );

    mae_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tsq_v),
        .i_t     (tsq_t),
        .i_r     (tsq_r),
        .i_q     (tsq_q),
        .i_den   (tsq_den),
        .i_flags (tsq_flags),
        .o_valid (o_valid),
        .o_asym  (o_asymmetry),
        .o_aerr  (o_asymmetry_error)
    );

    // A result beat follows an accepted beat by the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result beat without matching input beat");

    // Asymmetry stays within plus and minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_asymmetry) <= $signed(ASYM_W'(1) << ASYM_FRAC)) &&
                    ($signed(o_asymmetry) >= -$signed(ASYM_W'(1) << ASYM_FRAC)))
        else $error("asymmetry out of range");

    // Error sign follows a negative asymmetry
    a_neg_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_asymmetry[ASYM_W-1]) |->
            (o_asymmetry_error[AERR_W-1] || (o_asymmetry_error == '0)))
        else $error("error sign differs from negative asymmetry");

    // Error sign follows a positive asymmetry; a ratio rounded to zero may
    // still carry the sign of a tiny negative numerator
    a_pos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_asymmetry[ASYM_W-1] && (o_asymmetry != '0)) |->
            !o_asymmetry_error[AERR_W-1])
        else $error("error sign differs from positive asymmetry");

endmodule

>>> src/mae_ratio.sv
module mae_ratio import mae_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SQ_W-1:0]  i_sumsq,
    input  t_flags           i_flags,
    output logic             o_valid,
    output logic [ACC_W-1:0] o_acc,
    output logic [Q_W-1:0]   o_q,
    output logic [DEN_W-1:0] o_den,
    output t_flags           o_flags
);

    logic              r_v     [0:RAT_STG-1];
    logic [RREM_W-1:0] r_rem   [0:RAT_STG-1];
    logic [ACC_W-1:0]  r_acc   [0:RAT_STG-1];
    logic [DEN_W-1:0]  r_den   [0:RAT_STG-1];
    t_flags            r_flags [0:RAT_STG-1];
    logic [QIN_W-1:0]  r_s     [0:RAT_STG-1];
    logic [Q_W-1:0]    r_root  [0:RAT_STG-1];
    logic [QREM_W-1:0] r_qrem  [0:RAT_STG-1];

    logic             whole;
    logic [DEN_W-1:0] mag_ext;

    // Take out the integer bit of the ratio
    assign mag_ext = DEN_W'(i_mag);
    assign whole   = mag_ext >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0]   <= whole ? RREM_W'(mag_ext - i_den) : RREM_W'(mag_ext);
        r_acc[0]   <= ACC_W'(whole);
        r_den[0]   <= i_den;
        r_flags[0] <= i_flags;
        r_s[0]     <= QIN_W'(i_sumsq);
        r_root[0]  <= '0;
        r_qrem[0]  <= '0;
    end

    for (genvar g = 1; g < RAT_STG; g++) begin : g_stage
        logic [RREM_W-1:0] rem2;
        logic              ge;
        logic [RREM_W-1:0] n_rem;
        logic [Q_W-1:0]    n_root;
        logic [QREM_W-1:0] n_qrem;

        // One restoring division step per stage
        always_comb begin
            rem2  = {r_rem[g-1][RREM_W-2:0], 1'b0};
            ge    = rem2 >= RREM_W'(r_den[g-1]);
            n_rem = ge ? rem2 - RREM_W'(r_den[g-1]) : rem2;
        end

        // One root bit per stage while bits remain, then hold
        if (g <= Q_W) begin : g_sq
            logic [QREM_W+1:0] wide;
            logic [QREM_W+1:0] trial;
            always_comb begin
                wide  = {r_qrem[g-1], r_s[g-1][QIN_W-1-2*(g-1) -: 2]};
                trial = (QREM_W+2)'({r_root[g-1], 2'b01});
                if (wide >= trial) begin
                    n_qrem = QREM_W'(wide - trial);
                    n_root = {r_root[g-1][Q_W-2:0], 1'b1};
                end else begin
                    n_qrem = QREM_W'(wide);
                    n_root = {r_root[g-1][Q_W-2:0], 1'b0};
                end
            end
        end else begin : g_hold
            assign n_qrem = r_qrem[g-1];
            assign n_root = r_root[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= r_v[g-1];
            end
            r_rem[g]   <= n_rem;
            r_acc[g]   <= {r_acc[g-1][ACC_W-2:0], ge};
            r_den[g]   <= r_den[g-1];
            r_flags[g] <= r_flags[g-1];
            r_s[g]     <= r_s[g-1];
            r_root[g]  <= n_root;
            r_qrem[g]  <= n_qrem;
        end
    end

    assign o_valid = r_v[RAT_STG-1];
    assign o_acc   = r_acc[RAT_STG-1];
    assign o_q     = r_root[RAT_STG-1];
    assign o_den   = r_den[RAT_STG-1];
    assign o_flags = r_flags[RAT_STG-1];

endmodule

>>> src/mae_tsqrt.sv
module mae_tsqrt import mae_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [ACC_W-1:0] i_acc,
    input  logic [Q_W-1:0]   i_q,
    input  logic [DEN_W-1:0] i_den,
    input  t_flags           i_flags,
    output logic             o_valid,
    output logic [T_W-1:0]   o_t,
    output logic [R_W-1:0]   o_r,
    output logic [Q_W-1:0]   o_q,
    output logic [DEN_W-1:0] o_den,
    output t_flags           o_flags
);

    logic              r_v     [0:TSQ_STG-1];
    logic [R_W-1:0]    r_r     [0:TSQ_STG-1];
    logic [Q_W-1:0]    r_q     [0:TSQ_STG-1];
    logic [DEN_W-1:0]  r_den   [0:TSQ_STG-1];
    t_flags            r_flags [0:TSQ_STG-1];
    logic [TIN_W-1:0]  r_s     [0:TSQ_STG-1];
    logic [T_W-1:0]    r_root  [0:TSQ_STG-1];
    logic [TREM_W-1:0] r_trem  [0:TSQ_STG-1];

    logic [ACC_W:0] acc_inc;

    // Round the ratio to nearest, ties away from zero
    assign acc_inc = (ACC_W+1)'(i_acc) + (ACC_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
        end
        r_r[0]     <= R_W'(acc_inc[ACC_W:1]);
        r_q[0]     <= i_q;
        r_den[0]   <= i_den;
        r_flags[0] <= i_flags;
        r_s[0]     <= '0;
        r_root[0]  <= '0;
        r_trem[0]  <= '0;
        // Form 1 + r^2 in Q.60
        r_r[1]     <= r_r[0];
        r_q[1]     <= r_q[0];
        r_den[1]   <= r_den[0];
        r_flags[1] <= r_flags[0];
        r_s[1]     <= T_BASE + TIN_W'(r_r[0]) * TIN_W'(r_r[0]);
        r_root[1]  <= '0;
        r_trem[1]  <= '0;
    end

    for (genvar g = 2; g < TSQ_STG; g++) begin : g_stage
        localparam int K = g - 2;
        logic [TREM_W+1:0] wide;
        logic [TREM_W+1:0] trial;
        logic [TREM_W-1:0] n_trem;
        logic [T_W-1:0]    n_root;

        // One root bit per stage
        always_comb begin
            wide  = {r_trem[g-1], r_s[g-1][TIN_W-1-2*K -: 2]};
            trial = (TREM_W+2)'({r_root[g-1], 2'b01});
            if (wide >= trial) begin
                n_trem = TREM_W'(wide - trial);
                n_root = {r_root[g-1][T_W-2:0], 1'b1};
            end else begin
                n_trem = TREM_W'(wide);
                n_root = {r_root[g-1][T_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= r_v[g-1];
            end
            r_r[g]     <= r_r[g-1];
            r_q[g]     <= r_q[g-1];
            r_den[g]   <= r_den[g-1];
            r_flags[g] <= r_flags[g-1];
            r_s[g]     <= r_s[g-1];
            r_root[g]  <= n_root;
            r_trem[g]  <= n_trem;
        end
    end

    assign o_valid = r_v[TSQ_STG-1];
    assign o_t     = r_root[TSQ_STG-1];
    assign o_r     = r_r[TSQ_STG-1];
    assign o_q     = r_q[TSQ_STG-1];
    assign o_den   = r_den[TSQ_STG-1];
    assign o_flags = r_flags[TSQ_STG-1];

endmodule

>>> src/mae_qdiv.sv
module mae_qdiv import mae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [T_W-1:0]    i_t,
    input  logic [R_W-1:0]    i_r,
    input  logic [Q_W-1:0]    i_q,
    input  logic [DEN_W-1:0]  i_den,
    input  t_flags            i_flags,
    output logic              o_valid,
    output logic [ASYM_W-1:0] o_asym,
    output logic [AERR_W-1:0] o_aerr
);

    localparam int LAST = QDV_STG - 2;

    logic              r_v     [0:LAST];
    logic [R_W-1:0]    r_r     [0:LAST];
    logic [DEN_W-1:0]  r_den   [0:LAST];
    t_flags            r_flags [0:LAST];
    logic [NUMR_W-1:0] r_num   [0:LAST];
    logic [DV_W-1:0]   r_dv    [0:LAST];
    logic              r_ovf   [0:LAST];
    logic [DREM_W-1:0] r_rem   [0:LAST];
    logic [E_W-1:0]    r_quo   [0:LAST];

    logic              r_out_v;
    logic [ASYM_W-1:0] r_asym;
    logic [AERR_W-1:0] r_aerr;

    logic [NUMR_W-1:0] numr;
    logic [DV_W-1:0]   dv;

    // Add half the divisor for rounding, flag quotients past the output range
    assign numr = r_num[0] + (NUMR_W'(r_den[0]) << (DV_SH - 1));
    assign dv   = DV_W'(r_den[0]) << DV_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
        end
        // Product of the two roots
        r_r[0]     <= i_r;
        r_den[0]   <= i_den;
        r_flags[0] <= i_flags;
        r_num[0]   <= NUMR_W'(NUM_W'(i_q) * NUM_W'(i_t));
        r_dv[0]    <= '0;
        r_ovf[0]   <= 1'b0;
        r_rem[0]   <= '0;
        r_quo[0]   <= '0;
        r_r[1]     <= r_r[0];
        r_den[1]   <= r_den[0];
        r_flags[1] <= r_flags[0];
        r_num[1]   <= numr;
        r_dv[1]    <= dv;
        r_ovf[1]   <= DV_W'(numr[NUMR_W-1:E_W]) >= dv;
        r_rem[1]   <= DREM_W'(numr[NUMR_W-1:E_W]);
        r_quo[1]   <= '0;
    end

    for (genvar g = 2; g <= LAST; g++) begin : g_stage
        localparam int IDX = E_W - 1 - (g - 2);
        logic [DREM_W-1:0] rem2;
        logic              ge;

        // One quotient bit per stage
        always_comb begin
            rem2 = {r_rem[g-1][DREM_W-2:0], r_num[g-1][IDX]};
            ge   = rem2 >= DREM_W'(r_dv[g-1]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= r_v[g-1];
            end
            r_r[g]     <= r_r[g-1];
            r_den[g]   <= r_den[g-1];
            r_flags[g] <= r_flags[g-1];
            r_num[g]   <= r_num[g-1];
            r_dv[g]    <= r_dv[g-1];
            r_ovf[g]   <= r_ovf[g-1];
            r_rem[g]   <= ge ? rem2 - DREM_W'(r_dv[g-1]) : rem2;
            r_quo[g]   <= {r_quo[g-1][E_W-2:0], ge};
        end
    end

    logic [E_W-1:0] e_lim;
    logic [E_W-1:0] e_sat;

    // Saturate, then apply the sign of the numerator
    always_comb begin
        e_lim = r_flags[LAST].neg ? E_NEG_MAX : E_POS_MAX;
        e_sat = (r_ovf[LAST] || (r_quo[LAST] > e_lim)) ? e_lim : r_quo[LAST];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[LAST];
        end
        if (!r_flags[LAST].nz) begin
            r_asym <= '0;
            r_aerr <= '0;
        end else if (r_flags[LAST].neg) begin
            r_asym <= ASYM_W'(-ASYM_W'(r_r[LAST]));
            r_aerr <= AERR_W'(-e_sat);
        end else begin
            r_asym <= ASYM_W'(r_r[LAST]);
            r_aerr <= AERR_W'(e_sat);
        end
    end

    assign o_valid = r_out_v;
    assign o_asym  = r_asym;
    assign o_aerr  = r_aerr;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mae_pkg::*;

    localparam int N_RANDOM   = 1250;
    localparam int TAIL_ITEMS = 150;
    localparam int SETTLE     = LATENCY + 20;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ASYM_W-1:0] asym;
        logic [AERR_W-1:0] aerr;
    } t_asym_res;

    typedef struct {
        logic [COUNT_W-1:0] fwd;
        logic [COUNT_W-1:0] bwd;
        logic [ERR_W-1:0]   efwd;
        logic [ERR_W-1:0]   ebwd;
        bit                 typed;
        logic [ASYM_W-1:0]  asym;
        logic [AERR_W-1:0]  aerr;
    } t_bin_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_cfg_we = 1'b0;
    logic [BAL_W-1:0]  i_cfg_wdata = '0;
    logic [COUNT_W-1:0] i_forward_count = '0;
    logic [COUNT_W-1:0] i_backward_count = '0;
    logic [ERR_W-1:0]  i_forward_error = '0;
    logic [ERR_W-1:0]  i_backward_error = '0;
    logic              o_valid;
    logic [ASYM_W-1:0] o_asymmetry;
    logic [AERR_W-1:0] o_asymmetry_error;

    t_asym_res   expected_asym_q[$];
    logic [BAL_W-1:0] balance;
    int          n_errors = 0;
    longint      n_cycles = 0;
    t_bin_row    bin_table[$];

    muon_asymmetry_with_error dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_forward_count  (i_forward_count),
        .i_backward_count (i_backward_count),
        .i_forward_error  (i_forward_error),
        .i_backward_error (i_backward_error),
        .o_valid          (o_valid),
        .o_asymmetry      (o_asymmetry),
        .o_asymmetry_error(o_asymmetry_error)
    );

    always #10 i_clk = ~i_clk;

    // Integer square root, floor
    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Asymmetry and its error of one time bin under the current balance
    function automatic t_asym_res bin_asymmetry(input logic [COUNT_W-1:0] fwd,
            input logic [COUNT_W-1:0] bwd, input logic [ERR_W-1:0] efwd,
            input logic [ERR_W-1:0] ebwd);
        logic [63:0]  ab, fs, den, mag, rem, acc, r, q, t, dv, e;
        logic [127:0] num;
        logic         neg;
        t_asym_res    res;
        ab  = 64'(bwd) * 64'(balance);
        fs  = 64'(fwd) << 16;
        den = fs + ab;
        neg = ab > fs;
        mag = neg ? ab - fs : fs - ab;
        res = '0;
        if (den != 0 && mag != 0) begin
            acc = (mag >= den) ? 64'd1 : 64'd0;
            rem = mag - acc * den;
            for (int i = 0; i < 31; i++) begin
                rem = rem << 1;
                acc = acc << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    acc = acc | 64'd1;
                end
            end
            r   = (acc + 1) >> 1;
            q   = int_root(64'(efwd) * 64'(efwd) + 64'(ebwd) * 64'(ebwd));
            t   = int_root((64'd1 << 60) + r * r);
            num = 128'(q) * 128'(t);
            dv  = den << 6;
            e   = 64'((num + 128'(dv >> 1)) / 128'(dv));
            if (neg) begin
                if (e > 64'(E_NEG_MAX)) e = 64'(E_NEG_MAX);
                res.asym = ASYM_W'(-r);
                res.aerr = AERR_W'(-e);
            end else begin
                if (e > 64'(E_POS_MAX)) e = 64'(E_POS_MAX);
                res.asym = ASYM_W'(r);
                res.aerr = AERR_W'(e);
            end
        end
        return res;
    endfunction

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_asym_res want;
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_asym_q.size() == 0) begin
                $display("%0t: unexpected result asym=%h err=%h", $time,
                         o_asymmetry, o_asymmetry_error);
                n_errors++;
            end else begin
                want = expected_asym_q.pop_front();
                if (o_asymmetry !== want.asym) begin
                    $display("%0t: asymmetry expected %h actual %h", $time,
                             want.asym, o_asymmetry);
                    n_errors++;
                end
                if (o_asymmetry_error !== want.aerr) begin
                    $display("%0t: asymmetry_error expected %h actual %h", $time,
                             want.aerr, o_asymmetry_error);
                    n_errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (expected_asym_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_balance(input logic [BAL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        balance = val;
    endtask

    // Present one bin and hold it until taken
    task automatic send_bin(input logic [COUNT_W-1:0] fwd, input logic [COUNT_W-1:0] bwd,
            input logic [ERR_W-1:0] efwd, input logic [ERR_W-1:0] ebwd,
            input bit typed, input t_asym_res typed_res);
        start            <= 1'b1;
        i_forward_count  <= fwd;
        i_backward_count <= bwd;
        i_forward_error  <= efwd;
        i_backward_error <= ebwd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_asym_q.push_back(typed ? typed_res : bin_asymmetry(fwd, bwd, efwd, ebwd));
    endtask

    task automatic random_bins(input int count, input bit gaps);
        logic [COUNT_W-1:0] fwd, bwd;
        logic [ERR_W-1:0]   efwd, ebwd;
        int                 pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            fwd  = $urandom;
            bwd  = $urandom;
            if (pick == 0) bwd = fwd;
            if (pick == 1) fwd = $urandom_range(0, 255);
            if (pick == 2) bwd = $urandom_range(0, 255);
            if (pick == 3) begin fwd = '0; end
            efwd = (pick > 6) ? ERR_W'($urandom) : ERR_W'($urandom_range(0, 1 << 20));
            ebwd = (pick > 7) ? ERR_W'($urandom) : ERR_W'($urandom_range(0, 1 << 20));
            send_bin(fwd, bwd, efwd, ebwd, 1'b0, '0);
            // Drop start for a burst now and then
            if (gaps && $urandom_range(0, 7) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        t_bin_row row;
        logic [ERR_W-1:0] emax;
        emax = '1;
        // Directed bins: typed results where obvious
        bin_table.push_back('{0, 0, 0, 0, 1, 0, 0});
        bin_table.push_back('{0, 0, emax, emax, 1, 0, 0});
        bin_table.push_back('{100, 100, emax, emax, 1, 0, 0});
        bin_table.push_back('{'1, '1, 0, 0, 1, 0, 0});
        bin_table.push_back('{100, 0, 0, 0, 1, 32'h4000_0000, 0});
        bin_table.push_back('{0, 100, 0, 0, 1, 32'hC000_0000, 0});
        bin_table.push_back('{1, 0, emax, emax, 0, 0, 0});
        bin_table.push_back('{0, 1, emax, emax, 0, 0, 0});
        bin_table.push_back('{'1, 0, emax, 0, 0, 0, 0});
        bin_table.push_back('{0, '1, 0, emax, 0, 0, 0});
        bin_table.push_back('{'1, 1, 256, 256, 0, 0, 0});
        bin_table.push_back('{1, '1, 256, 256, 0, 0, 0});
        bin_table.push_back('{3, 1, 1, 1, 0, 0, 0});
        bin_table.push_back('{1000, 3000, 500, 900, 0, 0, 0});
        bin_table.push_back('{24'hAAAAAA, 24'h555555, 28'h5555555, 28'hAAAAAAA, 0, 0, 0});

        balance = BAL_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset balance of 1.0 first
        foreach (bin_table[k]) begin
            row = bin_table[k];
            send_bin(row.fwd, row.bwd, row.efwd, row.ebwd, row.typed, {row.asym, row.aerr});
        end
        start <= 1'b0;
        wait_drained();

        // Extremes of the balance factor, rows checked by the predictor
        write_balance('0);
        foreach (bin_table[k]) begin
            row = bin_table[k];
            send_bin(row.fwd, row.bwd, row.efwd, row.ebwd, 1'b0, '0);
        end
        start <= 1'b0;
        wait_drained();
        write_balance('1);
        foreach (bin_table[k]) begin
            row = bin_table[k];
            send_bin(row.fwd, row.bwd, row.efwd, row.ebwd, 1'b0, '0);
        end
        start <= 1'b0;
        wait_drained();

        // Random phases under several balances
        for (int ph = 0; ph < 5; ph++) begin
            write_balance(ph == 0 ? BAL_RESET : BAL_W'($urandom));
            random_bins((N_RANDOM - TAIL_ITEMS) / 5, 1'b1);
            wait_drained();
        end
        // Last stretch back to back
        write_balance(BAL_W'($urandom_range(1 << 15, 1 << 17)));
        random_bins(TAIL_ITEMS, 1'b0);
        wait_drained();

        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mae_pkg.sv
src/mae_ratio.sv
src/mae_tsqrt.sv
src/mae_qdiv.sv
src/muon_asymmetry_with_error.sv
sim/tb.sv
